>>> rtl/core/timed_effect_sequencer_top_defines.svh
// ----------------------------------------------------------------------------
// Timed effect sequencer assertion macros
// Shared property shorthands for the sequencer's RTL assertions.
// ----------------------------------------------------------------------------
`ifndef TIMED_EFFECT_SEQUENCER_TOP_DEFINES_SVH
`define TIMED_EFFECT_SEQUENCER_TOP_DEFINES_SVH

// Same-cycle implication, checked on aclk outside of reset.
`define TES_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on aclk outside of reset.
`define TES_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/tes_pkg.sv
// ----------------------------------------------------------------------------
// Timed effect sequencer package
// Beat types, register indexes, command codes and arithmetic constants.
// ----------------------------------------------------------------------------
package tes_pkg;

    localparam int unsigned DEFAULT_MAX_EFFECTS = 128;

    localparam logic [1:0] KIND_TICK = 2'd0;
    localparam logic [1:0] KIND_GOTO = 2'd1;
    localparam logic [1:0] KIND_NEXT = 2'd2;
    localparam logic [1:0] KIND_PREV = 2'd3;

    localparam logic [7:0] REG_ADVANCE_PERIOD = 8'd0;
    localparam logic [7:0] REG_FADE_PERIOD    = 8'd1;
    localparam logic [7:0] REG_SHUFFLE_MODE   = 8'd2;
    localparam logic [7:0] REG_EFFECT_COUNT   = 8'd3;

    localparam logic [30:0] ADVANCE_RESET = 31'd10000;
    localparam logic [30:0] FADE_RESET    = 31'd1000;
    localparam logic [7:0]  COUNT_RESET   = 8'd1;

    localparam logic [19:0] NS_PER_MS = 20'd1000000;
    localparam logic [31:0] LFSR_SEED = 32'hACE1_ACE1;
    localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;

    typedef struct packed {
        logic [1:0]  kind;
        logic [61:0] time_ns;
        logic [6:0]  target_index;
    } tes_in_t;

    typedef struct packed {
        logic [6:0] current_index;
        logic [6:0] next_index;
        logic       fading;
        logic [7:0] alpha;
        logic       rejected;
    } tes_out_t;

    typedef struct packed {
        logic [30:0] advance_period_ms;
        logic [30:0] fade_period_ms;
        logic        shuffle_mode;
        logic [7:0]  effect_count;
    } tes_cfg_t;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [63:0] divisor;
        logic [5:0]  steps;
    } tes_div_req_t;

    typedef struct packed {
        logic        busy;
        logic [63:0] rem;
        logic [8:0]  quot;
    } tes_div_sts_t;

endpackage

>>> rtl/core/tes_div_unit.sv
// ----------------------------------------------------------------------------
// Shared restoring divider
// One compare and subtract per cycle against a divisor that shifts right.
// ----------------------------------------------------------------------------
module tes_div_unit
    import tes_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  tes_div_req_t req,
    output tes_div_sts_t sts
);

    logic        busy_reg, busy_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [63:0] rem_reg, rem_next;
    logic [63:0] div_reg, div_next;
    logic [8:0]  quot_reg, quot_next;
    logic [64:0] diff;
    logic        ge;

    always_comb begin
        diff      = {1'b0, rem_reg} - {1'b0, div_reg};
        ge        = !diff[64];
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        quot_next = quot_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = req.steps;
            rem_next  = req.dividend;
            div_next  = req.divisor;
            quot_next = '0;
        end else if (busy_reg) begin
            if (ge) begin
                rem_next = diff[63:0];
            end
            quot_next = {quot_reg[7:0], ge};
            div_next  = {1'b0, div_reg[63:1]};
            cnt_next  = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg  <= rem_next;
        div_reg  <= div_next;
        quot_reg <= quot_next;
    end

    assign sts.busy = busy_reg;
    assign sts.rem  = rem_reg;
    assign sts.quot = quot_reg;

endmodule

>>> rtl/core/tes_core.sv
// ----------------------------------------------------------------------------
// Timed effect sequencer core
// Playlist state and the sequencer that drives the multiplier and divider.
// ----------------------------------------------------------------------------
`include "timed_effect_sequencer_top_defines.svh"

module tes_core
    import tes_pkg::*;
#(
    parameter int unsigned MAX_EFFECTS = DEFAULT_MAX_EFFECTS
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  tes_cfg_t cfg,
    input  logic     mark_clear,
    input  logic     s_valid,
    output logic     s_ready,
    input  tes_in_t  s_item,
    output logic     res_valid,
    input  logic     res_free,
    output tes_out_t res
);

    localparam logic [7:0] COUNT_LIMIT = (MAX_EFFECTS < 128) ? 8'(MAX_EFFECTS) : 8'd128;

    localparam logic [3:0] ST_IDLE       = 4'd0;
    localparam logic [3:0] ST_MUL_ADV    = 4'd1;
    localparam logic [3:0] ST_MUL_FADE   = 4'd2;
    localparam logic [3:0] ST_ADV_CHK    = 4'd3;
    localparam logic [3:0] ST_ADV_FIX    = 4'd4;
    localparam logic [3:0] ST_PICK_WAIT  = 4'd5;
    localparam logic [3:0] ST_FADE_CHK   = 4'd6;
    localparam logic [3:0] ST_ALPHA_WAIT = 4'd7;
    localparam logic [3:0] ST_CMD        = 4'd8;
    localparam logic [3:0] ST_CMD_WAIT   = 4'd9;
    localparam logic [3:0] ST_DONE       = 4'd10;

    logic [3:0]  state_reg, state_next;
    logic [1:0]  kind_reg, kind_next;
    logic [61:0] now_reg, now_next;
    logic [6:0]  target_reg, target_next;
    logic [50:0] adv_ns_reg, adv_ns_next;
    logic [50:0] fade_ns_reg, fade_ns_next;
    logic [61:0] mark_reg, mark_next;
    logic        mark_valid_reg, mark_valid_next;
    logic [6:0]  shown_reg, shown_next;
    logic [6:0]  pending_reg, pending_next;
    logic        pending_valid_reg, pending_valid_next;
    logic [31:0] lfsr_reg, lfsr_next;
    logic [7:0]  alpha_reg, alpha_next;
    logic        rejected_reg, rejected_next;

    tes_div_req_t div_req;
    tes_div_sts_t div_sts;

    logic [7:0]  count_raw;
    logic [7:0]  n;
    logic [30:0] mul_op;
    logic [50:0] mul_prod;
    logic [61:0] mark_sel;
    logic [62:0] adv_sum;
    logic        adv_due;
    logic [62:0] fix_sum;
    logic [62:0] fade_sum;
    logic        fade_over;
    logic [61:0] elapsed;
    logic [31:0] lfsr_step;
    logic [7:0]  cmd_rem;
    logic [7:0]  cmd_target;

    tes_div_unit u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .sts     (div_sts)
    );

    always_comb begin
        count_raw = (cfg.effect_count == 8'd0) ? 8'd1 : cfg.effect_count;
        n         = (count_raw > COUNT_LIMIT) ? COUNT_LIMIT : count_raw;
        mul_op    = (state_reg == ST_MUL_ADV) ? cfg.advance_period_ms : cfg.fade_period_ms;
        mul_prod  = {20'd0, mul_op} * {31'd0, NS_PER_MS};
        mark_sel  = mark_valid_reg ? mark_reg : now_reg;
        adv_sum   = {1'b0, mark_sel} + {12'd0, adv_ns_reg};
        adv_due   = (adv_ns_reg != '0) && (adv_sum <= {1'b0, now_reg});
        fix_sum   = {1'b0, mark_reg} + {12'd0, adv_ns_reg};
        fade_sum  = {1'b0, mark_reg} + {12'd0, fade_ns_reg};
        fade_over = fade_sum <= {1'b0, now_reg};
        elapsed   = now_reg - mark_reg;
        lfsr_step = {1'b0, lfsr_reg[31:1]} ^ (lfsr_reg[0] ? LFSR_TAPS : 32'd0);
        cmd_rem   = div_sts.rem[7:0];
        if (kind_reg == KIND_NEXT) begin
            cmd_target = cmd_rem;
        end else begin
            cmd_target = (cmd_rem == 8'd0) ? (n - 8'd1) : (cmd_rem - 8'd1);
        end
    end

    always_comb begin
        state_next         = state_reg;
        kind_next          = kind_reg;
        now_next           = now_reg;
        target_next        = target_reg;
        adv_ns_next        = adv_ns_reg;
        fade_ns_next       = fade_ns_reg;
        mark_next          = mark_reg;
        mark_valid_next    = mark_valid_reg;
        shown_next         = shown_reg;
        pending_next       = pending_reg;
        pending_valid_next = pending_valid_reg;
        lfsr_next          = lfsr_reg;
        alpha_next         = alpha_reg;
        rejected_next      = rejected_reg;
        div_req            = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    kind_next     = s_item.kind;
                    now_next      = s_item.time_ns;
                    target_next   = s_item.target_index;
                    alpha_next    = '0;
                    rejected_next = 1'b0;
                    state_next    = (s_item.kind == KIND_TICK) ? ST_MUL_ADV : ST_CMD;
                end
            end
            ST_MUL_ADV: begin
                adv_ns_next = mul_prod;
                state_next  = ST_MUL_FADE;
            end
            ST_MUL_FADE: begin
                fade_ns_next = mul_prod;
                state_next   = ST_ADV_CHK;
            end
            ST_ADV_CHK: begin
                mark_valid_next = 1'b1;
                if (adv_due) begin
                    if (pending_valid_reg) begin
                        shown_next = pending_reg;
                    end
                    mark_next  = adv_sum[61:0];
                    state_next = ST_ADV_FIX;
                end else begin
                    mark_next  = mark_sel;
                    state_next = ST_FADE_CHK;
                end
            end
            ST_ADV_FIX: begin
                if (fix_sum <= {1'b0, now_reg}) begin
                    mark_next = now_reg;
                end
                if (cfg.shuffle_mode) begin
                    lfsr_next        = lfsr_step;
                    div_req.start    = 1'b1;
                    div_req.dividend = {32'd0, lfsr_step};
                    div_req.divisor  = {25'd0, n, 31'd0};
                    div_req.steps    = 6'd32;
                    state_next       = ST_PICK_WAIT;
                end else if (pending_valid_reg) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = {56'd0, {1'b0, pending_reg} + 8'd1};
                    div_req.divisor  = {49'd0, n, 7'd0};
                    div_req.steps    = 6'd8;
                    state_next       = ST_PICK_WAIT;
                end else begin
                    pending_next       = '0;
                    pending_valid_next = 1'b1;
                    state_next         = ST_FADE_CHK;
                end
            end
            ST_PICK_WAIT: begin
                if (!div_sts.busy) begin
                    pending_next       = div_sts.rem[6:0];
                    pending_valid_next = 1'b1;
                    state_next         = ST_FADE_CHK;
                end
            end
            ST_FADE_CHK: begin
                if (pending_valid_reg && fade_over) begin
                    shown_next         = pending_reg;
                    pending_valid_next = 1'b0;
                    state_next         = ST_DONE;
                end else if (pending_valid_reg && (cfg.fade_period_ms != '0)
                             && (now_reg >= mark_reg)) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = {elapsed[55:0], 8'd0};
                    div_req.divisor  = {5'd0, fade_ns_reg, 8'd0};
                    div_req.steps    = 6'd9;
                    state_next       = ST_ALPHA_WAIT;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_ALPHA_WAIT: begin
                if (!div_sts.busy) begin
                    alpha_next = div_sts.quot[8] ? 8'hFF : div_sts.quot[7:0];
                    state_next = ST_DONE;
                end
            end
            ST_CMD: begin
                case (kind_reg)
                    KIND_GOTO: begin
                        if ({1'b0, target_reg} < n) begin
                            if (pending_valid_reg) begin
                                shown_next = pending_reg;
                            end
                            pending_next       = target_reg;
                            pending_valid_next = 1'b1;
                            mark_valid_next    = 1'b0;
                        end else begin
                            rejected_next = 1'b1;
                        end
                        state_next = ST_DONE;
                    end
                    KIND_NEXT: begin
                        div_req.start    = 1'b1;
                        div_req.dividend = {56'd0, {1'b0, shown_reg} + 8'd1};
                        div_req.divisor  = {49'd0, n, 7'd0};
                        div_req.steps    = 6'd8;
                        state_next       = ST_CMD_WAIT;
                    end
                    default: begin
                        div_req.start    = 1'b1;
                        div_req.dividend = {57'd0, shown_reg};
                        div_req.divisor  = {49'd0, n, 7'd0};
                        div_req.steps    = 6'd8;
                        state_next       = ST_CMD_WAIT;
                    end
                endcase
            end
            ST_CMD_WAIT: begin
                if (!div_sts.busy) begin
                    if (pending_valid_reg) begin
                        shown_next = pending_reg;
                    end
                    pending_next       = cmd_target[6:0];
                    pending_valid_next = 1'b1;
                    mark_valid_next    = 1'b0;
                    state_next         = ST_DONE;
                end
            end
            ST_DONE: begin
                if (res_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (mark_clear) begin
            mark_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            mark_reg          <= '0;
            mark_valid_reg    <= 1'b0;
            shown_reg         <= '0;
            pending_reg       <= '0;
            pending_valid_reg <= 1'b0;
            lfsr_reg          <= LFSR_SEED;
        end else begin
            state_reg         <= state_next;
            mark_reg          <= mark_next;
            mark_valid_reg    <= mark_valid_next;
            shown_reg         <= shown_next;
            pending_reg       <= pending_next;
            pending_valid_reg <= pending_valid_next;
            lfsr_reg          <= lfsr_next;
        end
        kind_reg     <= kind_next;
        now_reg      <= now_next;
        target_reg   <= target_next;
        adv_ns_reg   <= adv_ns_next;
        fade_ns_reg  <= fade_ns_next;
        alpha_reg    <= alpha_next;
        rejected_reg <= rejected_next;
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);

    assign res.current_index = shown_reg;
    assign res.next_index    = pending_valid_reg ? pending_reg : 7'd0;
    assign res.fading        = pending_valid_reg;
    assign res.alpha         = alpha_reg;
    assign res.rejected      = rejected_reg;

    `TES_ASSERT_NOW(a_div_idle_outside_waits, (state_reg == ST_IDLE || state_reg == ST_DONE), !div_sts.busy, "divider busy while the sequencer is idle or done")
    `TES_ASSERT_NOW(a_pick_below_count, (state_reg == ST_PICK_WAIT && !div_sts.busy), (div_sts.rem < {56'd0, n}), "picked index not below the effect count")
    `TES_ASSERT_NOW(a_alpha_only_fading, (state_reg == ST_DONE && !pending_valid_reg), (alpha_reg == 8'd0), "nonzero alpha without a crossfade")
    `TES_ASSERT_NOW(a_reject_only_goto, (state_reg == ST_DONE && rejected_reg), (kind_reg == KIND_GOTO), "reject flagged for a beat that is not a goto")
    `TES_ASSERT_NEXT(a_done_releases, (state_reg == ST_DONE && res_free), (state_reg == ST_IDLE), "result handed over but sequencer did not return to idle")

endmodule

>>> rtl/core/timed_effect_sequencer_top.sv
// ----------------------------------------------------------------------------
// Timed effect sequencer top level
// Configuration registers, sequencer core and the result output register.
// ----------------------------------------------------------------------------
// Usage: s_item beats carry a time tick (kind 0 with time_ns) or a goto, next
// or previous command. Every accepted beat yields exactly one m_result beat
// with the shown index, the index fading in, the fade flag, alpha and the
// goto reject flag. The cfg channel writes the four registers by index; it is
// ready whenever the sequencer is idle, and a write to the advance period
// clears the time mark.
// Flow: one item is worked on at a time. Its result reaches m_valid in the
// same cycle as the sequencer becomes ready for the next beat. A goto needs
// no division, and next and previous need an 8-step modulo. A tick may
// compute alpha with a 9-step division, and an advance may add an 8-step
// sequential pick or a 32-step shuffle pick. Every division runs on the
// shared one-bit-per-cycle divider.
// Reset: aresetn clears the playlist state, reloads the LFSR seed and the
// register defaults, and empties the output register.
// Stall: a finished result waits in the output register while the next beat
// is already accepted and worked on; that beat's result then waits in the
// core until the output register frees up.
module timed_effect_sequencer_top
    import tes_pkg::*;
#(
    parameter int unsigned MAX_EFFECTS = DEFAULT_MAX_EFFECTS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  tes_in_t     s_item,
    output logic        m_valid,
    input  logic        m_ready,
    output tes_out_t    m_result
);

    tes_cfg_t cfg_reg, cfg_next;
    logic     m_valid_reg, m_valid_next;
    tes_out_t m_result_reg, m_result_next;

    logic     cfg_write;
    logic     mark_clear;
    logic     core_ready;
    logic     res_valid;
    logic     res_free;
    tes_out_t res;

    assign cfg_ready = core_ready;
    assign cfg_write = cfg_valid && cfg_ready;
    assign res_free  = !m_valid_reg || m_ready;

    always_comb begin
        cfg_next   = cfg_reg;
        mark_clear = 1'b0;
        if (cfg_write) begin
            case (cfg_index)
                REG_ADVANCE_PERIOD: begin
                    cfg_next.advance_period_ms = cfg_data[30:0];
                    mark_clear                 = 1'b1;
                end
                REG_FADE_PERIOD: begin
                    cfg_next.fade_period_ms = cfg_data[30:0];
                end
                REG_SHUFFLE_MODE: begin
                    cfg_next.shuffle_mode = cfg_data[0];
                end
                REG_EFFECT_COUNT: begin
                    cfg_next.effect_count = cfg_data[7:0];
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_comb begin
        m_valid_next  = m_valid_reg;
        m_result_next = m_result_reg;
        if (res_valid && res_free) begin
            m_valid_next  = 1'b1;
            m_result_next = res;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.advance_period_ms <= ADVANCE_RESET;
            cfg_reg.fade_period_ms    <= FADE_RESET;
            cfg_reg.shuffle_mode      <= 1'b1;
            cfg_reg.effect_count      <= COUNT_RESET;
            m_valid_reg               <= 1'b0;
        end else begin
            cfg_reg     <= cfg_next;
            m_valid_reg <= m_valid_next;
        end
        m_result_reg <= m_result_next;
    end

    tes_core #(
        .MAX_EFFECTS (MAX_EFFECTS)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .mark_clear (mark_clear),
        .s_valid    (s_valid),
        .s_ready    (core_ready),
        .s_item     (s_item),
        .res_valid  (res_valid),
        .res_free   (res_free),
        .res        (res)
    );

    assign s_ready  = core_ready;
    assign m_valid  = m_valid_reg;
    assign m_result = m_result_reg;

endmodule

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// Timed effect sequencer regression bench
// Drives time ticks and goto, next and previous commands into the sequencer,
// predicts every status beat in step with the accepted input beats, and checks
// the returned beats field by field under several register settings and
// handshake idling mixes.
// ----------------------------------------------------------------------------
module tb_top
    import tes_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned PLAYLIST_LIMIT =
        (DEFAULT_MAX_EFFECTS < 128) ? DEFAULT_MAX_EFFECTS : 128;
    localparam logic [7:0] REG_SPARE = 8'd4;
    localparam int PHASES = 8;
    localparam int PHASE_BEATS = 147;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    tes_in_t     s_item = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    tes_out_t    m_result;

    timed_effect_sequencer_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

    always #5 aclk = ~aclk;

    // Shadow registers and playlist state.
    logic [30:0] adv_ms;
    logic [30:0] fade_ms;
    logic        shuffle;
    logic [7:0]  count_reg;
    logic [63:0] mark_ns;
    logic        mark_set;
    logic [6:0]  shown;
    logic [6:0]  pend;
    logic        pend_set;
    logic [31:0] lfsr;

    tes_in_t  beat_queue[$];
    tes_out_t expected_status[$];

    int src_idle_pct = 0;
    int snk_stall_pct = 0;
    int mismatches = 0;
    int results_checked = 0;
    int ticks_sent = 0;
    int commands_sent = 0;
    int rejects_sent = 0;
    int settings_used = 0;
    logic [61:0] clock_ns = '0;
    int unsigned span_us = 1;

    function automatic int unsigned live_count();
        int unsigned c;
        c = count_reg;
        if (c == 0) c = 1;
        if (c > PLAYLIST_LIMIT) c = PLAYLIST_LIMIT;
        return c;
    endfunction

    function automatic void start_fade(logic [6:0] target);
        if (pend_set) shown = pend;
        pend = target;
        pend_set = 1'b1;
        mark_set = 1'b0;
    endfunction

    function automatic tes_out_t advance_sequencer(tes_in_t beat);
        tes_out_t    status;
        logic [63:0] now_ns;
        logic [63:0] adv_ns;
        logic [63:0] fade_ns;
        logic [63:0] ratio;
        logic        lsb;
        int unsigned n;
        status = '0;
        now_ns = 64'(beat.time_ns);
        adv_ns = 64'(adv_ms) * 64'(NS_PER_MS);
        fade_ns = 64'(fade_ms) * 64'(NS_PER_MS);
        n = live_count();
        case (beat.kind)
            KIND_TICK: begin
                if (!mark_set) begin
                    mark_ns = now_ns;
                    mark_set = 1'b1;
                end
                if (adv_ns != 0 && mark_ns + adv_ns <= now_ns) begin
                    if (pend_set) shown = pend;
                    if (shuffle) begin
                        lsb = lfsr[0];
                        lfsr = lfsr >> 1;
                        if (lsb) lfsr = lfsr ^ LFSR_TAPS;
                        pend = 7'(lfsr % n);
                    end else begin
                        pend = pend_set ? 7'((32'(pend) + 1) % n) : 7'd0;
                    end
                    pend_set = 1'b1;
                    mark_ns = mark_ns + adv_ns;
                    if (mark_ns + adv_ns <= now_ns) mark_ns = now_ns;
                end
                if (pend_set && mark_ns + fade_ns <= now_ns) begin
                    shown = pend;
                    pend_set = 1'b0;
                end
                if (pend_set && fade_ms != 0 && now_ns >= mark_ns) begin
                    ratio = ((now_ns - mark_ns) * 64'd256) / fade_ns;
                    status.alpha = (ratio > 64'd255) ? 8'd255 : ratio[7:0];
                end
            end
            KIND_GOTO: begin
                if (32'(beat.target_index) < n) start_fade(beat.target_index);
                else status.rejected = 1'b1;
            end
            KIND_NEXT: start_fade(7'((32'(shown) + 1) % n));
            KIND_PREV: start_fade(7'((32'(shown) % n + n - 1) % n));
        endcase
        status.current_index = shown;
        status.next_index = pend_set ? pend : 7'd0;
        status.fading = pend_set;
        return status;
    endfunction

    function automatic tes_in_t random_beat();
        tes_in_t     beat;
        int unsigned r;
        int unsigned n;
        n = live_count();
        r = $urandom_range(99);
        beat.time_ns = 62'({$urandom, $urandom});
        beat.target_index = 7'($urandom);
        beat.kind = KIND_TICK;
        if (r < 62) begin
            clock_ns = clock_ns + 62'($urandom_range(span_us)) * 62'd1000
                + 62'($urandom_range(999));
            beat.time_ns = clock_ns;
        end else if (r < 66) begin
            clock_ns = clock_ns - (clock_ns >> $urandom_range(1, 8));
            beat.time_ns = clock_ns;
        end else if (r < 69) begin
            clock_ns = clock_ns + (62'($urandom) << $urandom_range(0, 30));
            beat.time_ns = clock_ns;
        end else if (r < 81) begin
            beat.kind = KIND_GOTO;
            if ($urandom_range(3) != 0) beat.target_index = 7'($urandom_range(n - 1));
        end else if (r < 91) begin
            beat.kind = KIND_NEXT;
        end else begin
            beat.kind = KIND_PREV;
        end
        return beat;
    endfunction

    // Input driver: presents queued beats, holding each until accepted.
    always @(posedge aclk) begin
        tes_out_t status;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                status = advance_sequencer(s_item);
                expected_status.push_back(status);
                if (s_item.kind == KIND_TICK) ticks_sent++;
                else commands_sent++;
                if (status.rejected) rejects_sent++;
            end
            if (!s_valid || s_ready) begin
                if (beat_queue.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    s_item <= beat_queue.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) m_ready <= ($urandom_range(99) >= snk_stall_pct);

    // Output monitor: every status beat is checked against the oldest prediction.
    always @(posedge aclk) begin
        tes_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_status.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected beat cur=%0d nxt=%0d fade=%0b alpha=%0d rej=%0b",
                             $realtime, m_result.current_index, m_result.next_index,
                             m_result.fading, m_result.alpha, m_result.rejected);
            end else begin
                want = expected_status.pop_front();
                results_checked++;
                if (m_result.current_index !== want.current_index ||
                    m_result.next_index !== want.next_index ||
                    m_result.fading !== want.fading ||
                    m_result.alpha !== want.alpha ||
                    m_result.rejected !== want.rejected) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: mismatch exp cur=%0d nxt=%0d fade=%0b alpha=%0d rej=%0b",
                                 $realtime, want.current_index, want.next_index,
                                 want.fading, want.alpha, want.rejected,
                                 " got cur=%0d nxt=%0d fade=%0b alpha=%0d rej=%0b",
                                 m_result.current_index, m_result.next_index,
                                 m_result.fading, m_result.alpha, m_result.rejected);
                end
            end
        end
    end

    task automatic wait_drain();
        @(negedge aclk);
        while (beat_queue.size() != 0 || s_valid || expected_status.size() != 0)
            @(negedge aclk);
    endtask

    task automatic set_register(input logic [7:0] idx, input logic [31:0] data);
        @(posedge aclk);
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_ADVANCE_PERIOD: begin
                adv_ms = data[30:0];
                mark_set = 1'b0;
            end
            REG_FADE_PERIOD: fade_ms = data[30:0];
            REG_SHUFFLE_MODE: shuffle = data[0];
            REG_EFFECT_COUNT: count_reg = data[7:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic push_beat(input logic [1:0] kind, input logic [61:0] stamp,
                             input logic [6:0] target);
        tes_in_t beat;
        beat.kind = kind;
        beat.time_ns = stamp;
        beat.target_index = target;
        beat_queue.push_back(beat);
    endtask

    initial begin
        logic [30:0] adv;
        logic [30:0] fade;
        logic [7:0]  cnt;
        logic [63:0] base_ms;
        logic [63:0] span64;
        adv_ms = ADVANCE_RESET;
        fade_ms = FADE_RESET;
        shuffle = 1'b1;
        count_reg = COUNT_RESET;
        mark_ns = '0;
        mark_set = 1'b0;
        shown = '0;
        pend = '0;
        pend_set = 1'b0;
        lfsr = LFSR_SEED;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        settings_used = 1;

        @(negedge aclk);
        push_beat(KIND_TICK, 62'd0, 7'd0);
        push_beat(KIND_TICK, 62'd10_000_000_000, 7'd127);
        push_beat(KIND_TICK, 62'd10_500_000_000, 7'd0);
        push_beat(KIND_TICK, 62'd11_000_000_000, 7'd0);
        push_beat(KIND_GOTO, 62'd0, 7'd0);
        push_beat(KIND_GOTO, {62{1'b1}}, 7'd1);
        push_beat(KIND_NEXT, 62'd0, 7'd0);
        push_beat(KIND_PREV, 62'd0, 7'd0);
        push_beat(KIND_TICK, {62{1'b1}}, 7'd0);
        push_beat(KIND_TICK, 62'd5, 7'd0);
        wait_drain();

        set_register(REG_ADVANCE_PERIOD, 32'd0);
        set_register(REG_FADE_PERIOD, 32'd1);
        set_register(REG_SHUFFLE_MODE, 32'd0);
        set_register(REG_EFFECT_COUNT, 32'd128);
        settings_used++;
        @(negedge aclk);
        push_beat(KIND_GOTO, 62'd0, 7'd127);
        push_beat(KIND_NEXT, 62'd0, 7'd0);
        push_beat(KIND_NEXT, 62'd0, 7'd0);
        push_beat(KIND_PREV, 62'd0, 7'd0);
        push_beat(KIND_TICK, 62'd0, 7'd0);
        push_beat(KIND_TICK, 62'd500_000, 7'd0);
        push_beat(KIND_TICK, 62'd1_000_000, 7'd0);
        push_beat(KIND_GOTO, 62'd0, 7'd100);
        push_beat(KIND_TICK, 62'd3_000_000, 7'd0);
        push_beat(KIND_TICK, 62'd4_000_000, 7'd0);
        wait_drain();

        set_register(REG_EFFECT_COUNT, 32'd5);
        set_register(REG_ADVANCE_PERIOD, 32'd2);
        set_register(REG_FADE_PERIOD, 32'd0);
        set_register(REG_SHUFFLE_MODE, 32'd1);
        settings_used++;
        @(negedge aclk);
        push_beat(KIND_NEXT, 62'd0, 7'd0);
        push_beat(KIND_PREV, 62'd0, 7'd0);
        push_beat(KIND_TICK, 62'd10_000_000, 7'd0);
        push_beat(KIND_TICK, 62'd12_000_000, 7'd0);
        push_beat(KIND_GOTO, 62'd0, 7'd5);

        for (int p = 0; p < PHASES; p++) begin
            adv = (p == 3) ? 31'd0 : (p == 5) ? 31'h7FFF_FFFF : 31'($urandom_range(1, 40));
            fade = (p == 2) ? 31'd0 : (p == 6) ? 31'h7FFF_FFFF : 31'($urandom_range(1, 30));
            cnt = (p == 1) ? 8'd0 : (p == 4) ? 8'd255 : (p == 7) ? 8'd128
                : 8'($urandom_range(1, 128));
            wait_drain();
            src_idle_pct = 0;
            snk_stall_pct = 0;
            if (p == 0) set_register(REG_SPARE, $urandom);
            set_register(REG_ADVANCE_PERIOD, {1'($urandom), adv});
            set_register(REG_FADE_PERIOD, {1'($urandom), fade});
            set_register(REG_SHUFFLE_MODE, {31'($urandom), 1'(p)});
            set_register(REG_EFFECT_COUNT, {24'($urandom), cnt});
            settings_used++;
            case (p % 4)
                1: src_idle_pct = 66;
                2: snk_stall_pct = 66;
                3: begin
                    src_idle_pct = 16;
                    snk_stall_pct = 16;
                end
                default: ;
            endcase
            if (adv == 0 && fade == 0) base_ms = 64'd10;
            else if (adv == 0) base_ms = 64'(fade);
            else if (fade == 0 || adv < fade) base_ms = 64'(adv);
            else base_ms = 64'(fade);
            span64 = base_ms * 64'd1000 / 64'd3;
            span_us = (span64 > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : span64[31:0];
            if (span_us == 0) span_us = 1;
            @(negedge aclk);
            for (int i = 0; i < PHASE_BEATS; i++) begin
                // Mid-phase the sender holds off until every status beat is back.
                if (i == PHASE_BEATS / 2) wait_drain();
                beat_queue.push_back(random_beat());
            end
        end

        wait_drain();
        repeat (64) @(posedge aclk);
        $display("Summary: %0d status beats checked from %0d ticks and %0d commands",
                 results_checked, ticks_sent, commands_sent);
        $display("Summary: %0d gotos rejected, %0d register settings, %0d mismatches",
                 rejects_sent, settings_used, mismatches);
        if (mismatches == 0 && expected_status.size() == 0) begin
            $display("timed_effect_sequencer_top regression: pass");
        end else begin
            $display("timed_effect_sequencer_top regression: fail");
        end
        $finish;
    end

    initial begin
        #(10_000_000);
        $display("Timeout with %0d status beats outstanding", expected_status.size());
        $display("timed_effect_sequencer_top regression: fail");
        $finish;
    end

endmodule
